/* hw/rtl/kmp_pkg.sv */
// Shared constants and types of the streaming KMP matcher.
`default_nettype none

package kmp_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int OFFSET_W    = 32;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_TEXT   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_FOLLOW,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/kmp_stream_matcher_top.sv */
// Top level of the streaming KMP matcher: sequencer, state and result register.
`default_nettype none

// Channel | Direction | Ports                                          | Handshake
// in      | input     | in_kind, in_data_byte, in_last_text            | in_valid / in_stall
// out     | output    | out_found, out_offset, out_pattern_overflow    | out_valid / out_stall
//
// Clear, the first pattern byte, full-pattern append, ignored text bytes and unused
// kinds are done in ST_IDLE. A pattern append or text byte that is searched goes on to
// ST_CMP, then ST_FOLLOW and ST_CMP again per fallback step: one compare against the
// pattern store and, on a mismatch, one prefix-table read, each through the single
// read port of its RAM. A text transaction that gives a result passes through ST_EMIT
// to the output register, and waits in ST_EMIT while an earlier result is held by out_stall;
// the next item is taken while that result waits in the output register.
// Reset (rst_n low, synchronous) empties the pattern and the text state; the
// RAMs are not cleared, since only written entries are ever read.

module kmp_stream_matcher_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_last_text,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_found,
  output logic [kmp_pkg::OFFSET_W-1:0]       out_offset,
  output logic                               out_pattern_overflow
);

  localparam int IW = kmp_pkg::IDX_W;
  localparam int LW = kmp_pkg::LEN_W;
  localparam int OW = kmp_pkg::OFFSET_W;

  function automatic logic [OW-1:0] sat_inc(input logic [OW-1:0] v);
    return (&v) ? v : v + OW'(1);
  endfunction

  kmp_pkg::state_t state_r, state_nxt;

  // search context
  logic          op_append_r, op_append_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic [LW-1:0] k_r, k_nxt;

  // pattern and text state
  logic [LW-1:0] plen_r, plen_nxt;
  logic [LW-1:0] bpl_r, bpl_nxt;
  logic [LW-1:0] match_r, match_nxt;
  logic [OW-1:0] tpos_r, tpos_nxt;
  logic          rep_r, rep_nxt;
  logic          ovf_r, ovf_nxt;

  // pending result
  logic          res_found_r, res_found_nxt;
  logic [OW-1:0] res_offset_r, res_offset_nxt;
  logic          res_ovf_r, res_ovf_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r, out_found_nxt;
  logic [OW-1:0] out_offset_r, out_offset_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  // RAM ports
  logic          ps_we, pt_we;
  logic [IW-1:0] ps_waddr, pt_waddr, ps_raddr, pt_raddr;
  logic [7:0]    ps_wdata, ps_rdata;
  logic [LW-1:0] pt_wdata, pt_rdata;

  logic          accept, slot_free, hit;
  logic [LW-1:0] k_dec, k_fin, back;
  logic [OW-1:0] tinc;

  kmp_ram #(.DATA_W(8), .DEPTH(kmp_pkg::MAX_PATTERN), .ADDR_W(IW)) u_pattern (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (ps_wdata),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  kmp_ram #(.DATA_W(LW), .DEPTH(kmp_pkg::MAX_PATTERN), .ADDR_W(IW)) u_prefix (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  assign in_stall  = (state_r != kmp_pkg::ST_IDLE);
  assign accept    = in_valid && (state_r == kmp_pkg::ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  assign hit   = (ps_rdata == byte_r);
  assign k_dec = k_r - LW'(1);
  assign k_fin = hit ? (k_r + LW'(1)) : '0;
  assign back  = plen_r - LW'(1);
  assign tinc  = sat_inc(tpos_r);

  always_comb begin
    state_nxt      = state_r;
    op_append_nxt  = op_append_r;
    byte_nxt       = byte_r;
    last_nxt       = last_r;
    k_nxt          = k_r;
    plen_nxt       = plen_r;
    bpl_nxt        = bpl_r;
    match_nxt      = match_r;
    tpos_nxt       = tpos_r;
    rep_nxt        = rep_r;
    ovf_nxt        = ovf_r;
    res_found_nxt  = res_found_r;
    res_offset_nxt = res_offset_r;
    res_ovf_nxt    = res_ovf_r;
    out_found_nxt  = out_found_r;
    out_offset_nxt = out_offset_r;
    out_ovf_nxt    = out_ovf_r;
    out_valid_nxt  = out_valid_r && out_stall;

    ps_we    = 1'b0;
    ps_waddr = plen_r[IW-1:0];
    ps_wdata = in_data_byte;
    ps_raddr = k_r[IW-1:0];
    pt_we    = 1'b0;
    pt_waddr = plen_r[IW-1:0];
    pt_wdata = '0;
    pt_raddr = k_dec[IW-1:0];

    case (state_r)
      kmp_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            kmp_pkg::KIND_CLEAR: begin
              plen_nxt  = '0;
              bpl_nxt   = '0;
              ovf_nxt   = 1'b0;
              match_nxt = '0;
              tpos_nxt  = '0;
              rep_nxt   = 1'b0;
            end
            kmp_pkg::KIND_APPEND: begin
              match_nxt = '0;
              tpos_nxt  = '0;
              rep_nxt   = 1'b0;
              if (plen_r == LW'(kmp_pkg::MAX_PATTERN)) begin
                ovf_nxt = 1'b1;
              end else begin
                ps_we = 1'b1;
                if (plen_r == '0) begin
                  pt_we    = 1'b1;
                  bpl_nxt  = '0;
                  plen_nxt = LW'(1);
                end else begin
                  op_append_nxt = 1'b1;
                  byte_nxt      = in_data_byte;
                  k_nxt         = bpl_r;
                  ps_raddr      = bpl_r[IW-1:0];
                  state_nxt     = kmp_pkg::ST_CMP;
                end
              end
            end
            kmp_pkg::KIND_TEXT: begin
              if (rep_r) begin
                // matched already: bytes are dropped until the text ends
                if (in_last_text) begin
                  match_nxt = '0;
                  tpos_nxt  = '0;
                  rep_nxt   = 1'b0;
                end
              end else if (plen_r == '0) begin
                // empty pattern matches at the first byte
                res_found_nxt  = 1'b1;
                res_offset_nxt = '0;
                res_ovf_nxt    = ovf_r;
                rep_nxt        = 1'b1;
                tpos_nxt       = tinc;
                if (in_last_text) begin
                  match_nxt = '0;
                  tpos_nxt  = '0;
                  rep_nxt   = 1'b0;
                end
                state_nxt = kmp_pkg::ST_EMIT;
              end else begin
                op_append_nxt = 1'b0;
                byte_nxt      = in_data_byte;
                last_nxt      = in_last_text;
                k_nxt         = match_r;
                ps_raddr      = match_r[IW-1:0];
                state_nxt     = kmp_pkg::ST_CMP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      kmp_pkg::ST_CMP: begin
        if (!hit && (k_r != '0)) begin
          // mismatch: fall back through the prefix table
          state_nxt = kmp_pkg::ST_FOLLOW;
        end else if (op_append_r) begin
          pt_we     = 1'b1;
          pt_wdata  = k_fin;
          bpl_nxt   = k_fin;
          plen_nxt  = plen_r + LW'(1);
          state_nxt = kmp_pkg::ST_IDLE;
        end else begin
          match_nxt = k_fin;
          tpos_nxt  = tinc;
          state_nxt = kmp_pkg::ST_IDLE;
          res_ovf_nxt = ovf_r;
          if (k_fin == plen_r) begin
            rep_nxt        = 1'b1;
            res_found_nxt  = 1'b1;
            res_offset_nxt = (tpos_r >= OW'(back)) ? (tpos_r - OW'(back)) : '0;
            state_nxt      = kmp_pkg::ST_EMIT;
          end else if (last_r) begin
            res_found_nxt  = 1'b0;
            res_offset_nxt = tinc;
            state_nxt      = kmp_pkg::ST_EMIT;
          end
          if (last_r) begin
            match_nxt = '0;
            tpos_nxt  = '0;
            rep_nxt   = 1'b0;
          end
        end
      end

      kmp_pkg::ST_FOLLOW: begin
        k_nxt     = pt_rdata;
        ps_raddr  = pt_rdata[IW-1:0];
        state_nxt = kmp_pkg::ST_CMP;
      end

      kmp_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_offset_nxt = res_offset_r;
          out_ovf_nxt    = res_ovf_r;
          state_nxt      = kmp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = kmp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kmp_pkg::ST_IDLE;
      plen_r      <= '0;
      bpl_r       <= '0;
      match_r     <= '0;
      tpos_r      <= '0;
      rep_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      bpl_r       <= bpl_nxt;
      match_r     <= match_nxt;
      tpos_r      <= tpos_nxt;
      rep_r       <= rep_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_append_r  <= op_append_nxt;
    byte_r       <= byte_nxt;
    last_r       <= last_nxt;
    k_r          <= k_nxt;
    res_found_r  <= res_found_nxt;
    res_offset_r <= res_offset_nxt;
    res_ovf_r    <= res_ovf_nxt;
    out_found_r  <= out_found_nxt;
    out_offset_r <= out_offset_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_found            = out_found_r;
  assign out_offset           = out_offset_r;
  assign out_pattern_overflow = out_ovf_r;

  a_k_in_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kmp_pkg::ST_CMP) |-> (k_r < plen_r))
    else $error("search index beyond pattern length");

  a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= LW'(kmp_pkg::MAX_PATTERN))
    else $error("pattern length beyond capacity");

  a_bpl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (plen_r != '0) |-> (bpl_r < plen_r))
    else $error("build prefix length not below pattern length");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kmp_pkg::ST_EMIT && slot_free) |=> out_valid_r)
    else $error("pending result not moved to output register");

  a_match_open: assert property (@(posedge clk) disable iff (!rst_n)
    !rep_r |-> (match_r < plen_r || plen_r == '0))
    else $error("full match held without being reported");

endmodule

`default_nettype wire

/* hw/rtl/kmp_ram.sv */
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module kmp_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
